>>> rtl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// shared constants for the scratchpad decoder: byte positions, crc and
// temperature conversion constants
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

  // byte positions inside the nine-byte scratchpad
  localparam logic [3:0] POS_TEMP_LSB   = 4'd0;
  localparam logic [3:0] POS_TEMP_MSB   = 4'd1;
  localparam logic [3:0] POS_CONFIG     = 4'd4;
  localparam logic [3:0] POS_COUNT_REM  = 4'd6;
  localparam logic [3:0] POS_COUNT_PER  = 4'd7;
  localparam logic [3:0] POS_CRC        = 4'd8;
  localparam logic [3:0] POS_DONE       = 4'd9;

  // reflected x^8+x^5+x^4+1
  localparam logic [7:0] CRC_POLY       = 8'h8C;

  localparam logic [7:0] LEGACY_FAMILY  = 8'h10;
  localparam logic [7:0] LEGACY_CPD     = 8'h10;
  localparam logic [15:0] LEGACY_MASK   = 16'hFFF0;
  localparam logic [15:0] LEGACY_BIAS   = 16'd12;

  // resolution field, bits 6:5 of the config byte
  localparam logic [1:0] RES_9BIT       = 2'b00;
  localparam logic [1:0] RES_10BIT      = 2'b01;
  localparam logic [1:0] RES_11BIT      = 2'b10;
  localparam logic [15:0] MASK_9BIT     = 16'hFFF8;
  localparam logic [15:0] MASK_10BIT    = 16'hFFFC;
  localparam logic [15:0] MASK_11BIT    = 16'hFFFE;

endpackage

`default_nettype wire

>>> rtl/tsd_if.sv
// ----------------------------------------------------------------------------
// tsd channel interfaces
// valid/ready channels for scratchpad byte requests and decoded results
// ----------------------------------------------------------------------------
`default_nettype none

interface tsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] family_code;
  logic       frame_start;

  modport source (output valid, output data_byte, output family_code,
                  output frame_start, input ready);
  modport sink   (input valid, input data_byte, input family_code,
                  input frame_start, output ready);
endinterface

interface tsd_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic               crc_ok;

  modport source (output valid, output temperature, output crc_ok, input ready);
  modport sink   (input valid, input temperature, input crc_ok, output ready);
endinterface

`default_nettype wire

>>> rtl/tsd_crc8.sv
// ----------------------------------------------------------------------------
// tsd_crc8
// one-byte update of the reflected crc-8, unrolled over the eight bits
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_crc8
  import tsd_pkg::*;
(
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data,
  output logic      [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

>>> rtl/temperature_scratchpad_decoder_unit.sv
// ----------------------------------------------------------------------------
// temperature_scratchpad_decoder_unit
// output: a result appears in the cycle after byte 8 of a frame is accepted
// throughput: one byte request per cycle, limited only by the result register
// reset: synchronous rst clears the byte counter, crc, captured bytes and the
//   result valid flag; the first byte after reset is taken as byte 0
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_scratchpad_decoder_unit
  import tsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  tsd_byte_if.sink    sample,
  tsd_result_if.source result
);

  // frame state
  logic [3:0] byte_position;
  logic [7:0] running_crc;
  logic [7:0] temp_low;
  logic [7:0] temp_high;
  logic [7:0] resolution_byte;
  logic [7:0] count_remain;
  logic [7:0] count_per_degree;
  logic       legacy_family;

  // result register
  logic               res_valid;
  logic signed [15:0] res_temperature;
  logic               res_crc_ok;

  logic       accept;
  logic [3:0] pos_eff;
  logic [7:0] crc_seed;
  logic [7:0] crc_upd;
  logic       emit;
  logic       crc_match;
  logic [15:0] raw;
  logic [15:0] raw_shift;
  logic [15:0] temp_dec;

  // a new request is taken whenever the result slot is free or draining
  assign sample.ready = !res_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  // frame_start forces byte 0 and a fresh crc
  assign pos_eff  = sample.frame_start ? POS_TEMP_LSB : byte_position;
  assign crc_seed = (pos_eff == POS_TEMP_LSB) ? 8'h00 : running_crc;
  assign emit     = accept && (pos_eff == POS_CRC);

  tsd_crc8 u_crc (
    .crc_in  (crc_seed),
    .data    (sample.data_byte),
    .crc_out (crc_upd)
  );

  assign crc_match = (running_crc == sample.data_byte);

  // temperature decode from the captured bytes
  assign raw       = {temp_high, temp_low};
  assign raw_shift = raw << 3;

  always_comb begin
    temp_dec = raw;
    if (legacy_family) begin
      temp_dec = raw_shift;
      // count-remain refinement for the legacy part, wraps at 16 bits
      if (count_per_degree == LEGACY_CPD) begin
        temp_dec = (raw_shift & LEGACY_MASK) + LEGACY_BIAS - {8'd0, count_remain};
      end
    end else begin
      case (resolution_byte[6:5])
        RES_9BIT:  temp_dec = raw & MASK_9BIT;
        RES_10BIT: temp_dec = raw & MASK_10BIT;
        RES_11BIT: temp_dec = raw & MASK_11BIT;
        default:   temp_dec = raw;
      endcase
    end
  end

  // frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= POS_TEMP_LSB;
      running_crc      <= 8'h00;
      temp_low         <= 8'h00;
      temp_high        <= 8'h00;
      resolution_byte  <= 8'h00;
      count_remain     <= 8'h00;
      count_per_degree <= 8'h00;
      legacy_family    <= 1'b0;
    end else if (accept) begin
      if (pos_eff == POS_CRC) begin
        byte_position <= POS_DONE;
      end else if (pos_eff < POS_CRC) begin
        case (pos_eff)
          POS_TEMP_LSB: begin
            temp_low      <= sample.data_byte;
            legacy_family <= (sample.family_code == LEGACY_FAMILY);
          end
          POS_TEMP_MSB:  temp_high        <= sample.data_byte;
          POS_CONFIG:    resolution_byte  <= sample.data_byte;
          POS_COUNT_REM: count_remain     <= sample.data_byte;
          POS_COUNT_PER: count_per_degree <= sample.data_byte;
          default: ;
        endcase
        running_crc   <= crc_upd;
        byte_position <= pos_eff + 4'd1;
      end
      // extra bytes past the crc byte are dropped
    end
  end

  // result register: loads on the crc byte, clears once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_crc_ok      <= crc_match;
      res_temperature <= crc_match ? $signed(temp_dec) : 16'sd0;
    end
  end

  assign result.valid       = res_valid;
  assign result.temperature = res_temperature;
  assign result.crc_ok      = res_crc_ok;

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_DONE)
    else $error("byte counter beyond done");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> result.valid)
    else $error("crc byte gave no result");

  a_bad_crc_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.crc_ok) |-> (result.temperature == 16'sd0))
    else $error("bad crc result carries a temperature");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !sample.frame_start && byte_position < POS_CRC)
      |=> (byte_position == $past(byte_position) + 4'd1))
    else $error("byte counter did not advance");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> result.valid)
    else $error("pending result lost");

endmodule

`default_nettype wire

>>> tb/temperature_scratchpad_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// temperature_scratchpad_decoder_unit_test
// drives scratchpad byte requests into the decoder and checks every decoded
// reading against a cycle-free model of the crc-8 and temperature rules;
// directed frames first, then random frames, broken frames and noise, with
// random idle cycles on the byte side and random stalls on the result side
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_scratchpad_decoder_unit_test
  import tsd_pkg::*;
();

  // cycles with no handshake on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic               crc_ok;
  } decoded_frame_t;

  logic clk;
  logic rst;

  tsd_byte_if   sample_ch ();
  tsd_result_if result_ch ();

  temperature_scratchpad_decoder_unit dut (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_ch),
    .result(result_ch)
  );

  // idle and stall rates in percent, zeroed during the back-to-back test
  int unsigned send_idle_pct = 30;
  int unsigned recv_stall_pct = 30;

  // model state, mirrors the decoder between requests
  logic [3:0] model_pos;
  logic [7:0] model_crc;
  logic [7:0] model_temp_lo;
  logic [7:0] model_temp_hi;
  logic [7:0] model_config;
  logic [7:0] model_count_rem;
  logic [7:0] model_count_per;
  logic       model_legacy;

  // readings still owed by the decoder, oldest first
  decoded_frame_t pending_readings[$];

  int unsigned bytes_accepted = 0;
  int unsigned readings_checked = 0;
  int unsigned bad_crc_readings = 0;
  int unsigned legacy_readings = 0;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------

  // reflected crc-8, one bit at a time, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  // temperature in sixteenths of a degree from the captured bytes
  function automatic logic [15:0] decode_reading();
    logic [15:0] raw;
    raw = {model_temp_hi, model_temp_lo};
    if (model_legacy) begin
      // short-resolution family: half-degree steps scaled up, wraps at 16 bits
      raw = raw << 3;
      if (model_count_per == LEGACY_CPD) begin
        raw = (raw & LEGACY_MASK) + LEGACY_BIAS - {8'h00, model_count_rem};
      end
    end else begin
      case (model_config[6:5])
        RES_9BIT:  raw = raw & MASK_9BIT;
        RES_10BIT: raw = raw & MASK_10BIT;
        RES_11BIT: raw = raw & MASK_11BIT;
        default:   raw = raw;
      endcase
    end
    return raw;
  endfunction

  // advance the model by one accepted byte, queue a reading on the crc byte
  task automatic track_scratchpad_byte(input logic [7:0] b, input logic [7:0] fam,
                                       input logic start);
    decoded_frame_t r;
    if (start) begin
      model_pos = POS_TEMP_LSB;
      model_crc = 8'h00;
    end
    if (model_pos == POS_CRC) begin
      r.crc_ok      = (model_crc == b);
      r.temperature = r.crc_ok ? decode_reading() : 16'sd0;
      if (!r.crc_ok) begin
        bad_crc_readings++;
      end else if (model_legacy) begin
        legacy_readings++;
      end
      pending_readings.push_back(r);
      model_pos = POS_DONE;
    end else if (model_pos < POS_CRC) begin
      case (model_pos)
        POS_TEMP_LSB: begin
          model_crc     = 8'h00;
          model_legacy  = (fam == LEGACY_FAMILY);
          model_temp_lo = b;
        end
        POS_TEMP_MSB:  model_temp_hi = b;
        POS_CONFIG:    model_config = b;
        POS_COUNT_REM: model_count_rem = b;
        POS_COUNT_PER: model_count_per = b;
        default: ;
      endcase
      model_crc = crc8_update(model_crc, b);
      model_pos = model_pos + 4'd1;
    end
    // past the crc byte and no frame start: byte is dropped
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls and the checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    decoded_frame_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: temperature %0d crc_ok %0b",
               $signed(result_ch.temperature), result_ch.crc_ok);
        error_count++;
      end else begin
        exp_r = pending_readings.pop_front();
        readings_checked++;
        if (result_ch.temperature !== exp_r.temperature) begin
          $error("temperature mismatch: expected %0d, actual %0d",
                 $signed(exp_r.temperature), $signed(result_ch.temperature));
          error_count++;
        end
        if (result_ch.crc_ok !== exp_r.crc_ok) begin
          $error("crc_ok mismatch: expected %0b, actual %0b", exp_r.crc_ok, result_ch.crc_ok);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any handshake clears the count
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no request or reading moved for %0d cycles", STALL_LIMIT);
    $display("temperature_scratchpad_decoder_unit_test NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // byte side
  // --------------------------------------------------------------------------

  // one byte request; returns at the edge that accepted it with valid still high
  task automatic send_byte(input logic [7:0] b, input logic [7:0] fam, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.data_byte   <= b;
    sample_ch.family_code <= fam;
    sample_ch.frame_start <= start;
    do @(posedge clk); while (!sample_ch.ready);
    bytes_accepted++;
    track_scratchpad_byte(b, fam, start);
  endtask

  // eight body bytes plus the crc byte, optionally corrupted
  task automatic send_frame(input logic [7:0] fam_first, input logic [7:0] fam_rest,
                            input logic [7:0] body [8], input bit mark_start,
                            input bit corrupt);
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < 8; i++) crc = crc8_update(crc, body[i]);
    if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 8; i++) begin
      send_byte(body[i], (i == 0) ? fam_first : fam_rest, mark_start && (i == 0));
    end
    send_byte(crc, fam_rest, 1'b0);
  endtask

  // frame with random content, crc corrupted with the given percent chance
  task automatic send_random_frame(input bit legacy, input int unsigned corrupt_pct);
    logic [7:0] body [8];
    logic [7:0] fam;
    for (int i = 0; i < 8; i++) body[i] = 8'($urandom);
    if (legacy) begin
      fam = LEGACY_FAMILY;
      // most legacy parts report sixteen counts per degree
      if ($urandom_range(99) < 75) body[POS_COUNT_PER] = LEGACY_CPD;
    end else begin
      fam = 8'($urandom);
      if (fam == LEGACY_FAMILY) fam = 8'h28;
    end
    send_frame(fam, 8'($urandom), body, 1'b1, $urandom_range(99) < corrupt_pct);
  endtask

  // hold the sender until the decoder owes nothing
  task automatic wait_readings_drained();
    sample_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // first frame after reset has no frame start; legacy wraparound at the
  // extremes, then a trailing byte that must be ignored
  task automatic check_power_up_frame();
    logic [7:0] body [8];
    body = '{8'hFF, 8'h7F, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, LEGACY_CPD};
    send_frame(LEGACY_FAMILY, 8'h00, body, 1'b0, 1'b0);
    send_byte(8'h00, LEGACY_FAMILY, 1'b0);
  endtask

  // frame start mid-frame drops the partial frame; family is taken only at
  // byte 0 even though later bytes carry the legacy code
  task automatic check_restart_mid_frame();
    logic [7:0] body [8];
    send_byte(8'h55, LEGACY_FAMILY, 1'b1);
    send_byte(8'hAA, LEGACY_FAMILY, 1'b0);
    send_byte(8'h01, LEGACY_FAMILY, 1'b0);
    body = '{8'h91, 8'h01, 8'h4B, 8'h46, 8'h1F, 8'hFF, 8'h0F, 8'h10};
    send_frame(8'h00, LEGACY_FAMILY, body, 1'b1, 1'b0);
  endtask

  // legacy family with and without count-remain refinement, one drain pause
  task automatic check_legacy_frames();
    for (int n = 0; n < 50; n++) begin
      if (n == 25) wait_readings_drained();
      send_random_frame(1'b1, 10);
    end
  endtask

  // other families across all four resolution settings
  task automatic check_resolution_frames();
    for (int n = 0; n < 60; n++) send_random_frame(1'b0, 10);
  endtask

  // stretch with no idle cycles and no stalls on either side
  task automatic check_back_to_back();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 25; n++) send_random_frame(1'($urandom_range(1)), 15);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
  endtask

  // bad crcs, frames cut short, lone bytes and trailing bytes
  task automatic check_corrupt_frames();
    int unsigned stop_at;
    int unsigned pick;
    int unsigned cut;
    stop_at = bytes_accepted + 400;
    while (bytes_accepted < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_random_frame(1'($urandom_range(1)), 50);
      end else if (pick < 70) begin
        // partial frame, the next frame start throws it away
        cut = $urandom_range(1, 8);
        for (int i = 0; i < cut; i++) begin
          send_byte(8'($urandom), 8'($urandom), i == 0);
        end
      end else if (pick < 85) begin
        send_byte(8'($urandom), 8'($urandom), $urandom_range(99) < 30);
      end else begin
        send_random_frame(1'($urandom_range(1)), 10);
        cut = $urandom_range(1, 3);
        for (int i = 0; i < cut; i++) send_byte(8'($urandom), 8'($urandom), 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                   <= 1'b1;
    sample_ch.valid       <= 1'b0;
    sample_ch.data_byte   <= 8'h00;
    sample_ch.family_code <= 8'h00;
    sample_ch.frame_start <= 1'b0;
    model_pos       = 4'd0;
    model_crc       = 8'h00;
    model_temp_lo   = 8'h00;
    model_temp_hi   = 8'h00;
    model_config    = 8'h00;
    model_count_rem = 8'h00;
    model_count_per = 8'h00;
    model_legacy    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_power_up_frame();
    check_restart_mid_frame();
    check_legacy_frames();
    check_resolution_frames();
    check_back_to_back();
    check_corrupt_frames();

    // settle: decoder answers in the cycle after the crc byte
    wait_readings_drained();
    repeat (4) @(posedge clk);

    $display("covered %0d byte requests, %0d readings checked (%0d legacy, %0d bad crc)",
             bytes_accepted, readings_checked, legacy_readings, bad_crc_readings);
    $display("with mid-frame restarts, ignored trailing bytes, idle gaps and result stalls");
    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("temperature_scratchpad_decoder_unit_test OK");
    end else begin
      $display("temperature_scratchpad_decoder_unit_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
